// ===== hdl/nse_pkg.sv =====
`default_nettype none

package nse_pkg;

    // angle and code formats
    localparam int PHASE_W    = 32;
    localparam int PROD_W     = PHASE_W + 8;
    localparam int CODE_W     = 8;
    localparam int MAX_STAGES = 32;

    // cordic datapath: fraction bits added on entry and growth headroom
    localparam int FRAC_SHIFT = 16;
    localparam int HEADROOM   = 3;

    localparam logic [PHASE_W-1:0] PHASE_PI  = 32'h8000_0000;
    localparam logic [PHASE_W-1:0] PHASE_ZERO = 32'h0000_0000;

    // rounding bias for truncation toward zero of a negative product
    localparam logic [PROD_W-1:0] TRUNC_BIAS = 40'h00_FFFF_FFFF;

    localparam logic [CODE_W-1:0] CODE_ZERO      = 8'd0;
    localparam logic [CODE_W-1:0] CODE_HALF_TURN = 8'd127;
    localparam logic [CODE_W-1:0] CODE_MAX       = 8'd255;

    // atan(2^-i) as a binary phase, full turn = 2^32
    localparam logic [PHASE_W-1:0] ATAN_PHASE [0:MAX_STAGES-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // flags that ride along with the azimuth cordic
    typedef struct packed {
        logic xy_zero;
        logic y_zero;
        logic x_neg;
    } az_flags_t;

    // flags that ride along with the polar cordic
    typedef struct packed {
        logic pole;
        logic z_neg;
    } po_flags_t;

endpackage

`default_nettype wire

// ===== hdl/nse_isqrt.sv =====
`default_nettype none

module nse_isqrt #(
    parameter int RAD_W  = 32,
    parameter int SIDE_W = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic [RAD_W-1:0]     radicand,
    input  logic [SIDE_W-1:0]    side_in,
    output logic                 out_valid,
    output logic [RAD_W/2-1:0]   root,
    output logic [SIDE_W-1:0]    side_out
);

    localparam int N = RAD_W / 2;

    logic [RAD_W-1:0]  v_stage     [0:N];
    logic [RAD_W:0]    r_stage     [0:N];
    logic              valid_stage [0:N];
    logic [SIDE_W-1:0] side_stage  [0:N];

    logic [RAD_W-1:0]  v_reg     [0:N-1];
    logic [RAD_W:0]    r_reg     [0:N-1];
    logic              valid_reg [0:N-1];
    logic [SIDE_W-1:0] side_reg  [0:N-1];

    assign v_stage[0]     = radicand;
    assign r_stage[0]     = '0;
    assign valid_stage[0] = in_valid;
    assign side_stage[0]  = side_in;

    // one result bit per stage, restoring digit recurrence
    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam logic [RAD_W:0] BIT_K = {{RAD_W{1'b0}}, 1'b1} << (2 * (N - 1 - k));

        logic [RAD_W:0]   trial;
        logic [RAD_W-1:0] v_next;
        logic [RAD_W:0]   r_next;

        always_comb
        begin
            trial = r_stage[k] + BIT_K;
            if ({1'b0, v_stage[k]} >= trial)
            begin
                v_next = v_stage[k] - trial[RAD_W-1:0];
                r_next = (r_stage[k] >> 1) + BIT_K;
            end
            else
            begin
                v_next = v_stage[k];
                r_next = r_stage[k] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[k] <= valid_stage[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                v_reg[k]    <= v_next;
                r_reg[k]    <= r_next;
                side_reg[k] <= side_stage[k];
            end
        end

        assign v_stage[k+1]     = v_reg[k];
        assign r_stage[k+1]     = r_reg[k];
        assign valid_stage[k+1] = valid_reg[k];
        assign side_stage[k+1]  = side_reg[k];
    end

    assign out_valid = valid_stage[N];
    assign root      = r_stage[N][N-1:0];
    assign side_out  = side_stage[N];

endmodule

`default_nettype wire

// ===== hdl/nse_cordic.sv =====
`default_nettype none

module nse_cordic #(
    parameter int IN_W   = 16,
    parameter int STAGES = 16,
    parameter int SIDE_W = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic signed [IN_W-1:0]        vec_x,
    input  logic signed [IN_W-1:0]        vec_y,
    input  logic [SIDE_W-1:0]             side_in,
    output logic                          out_valid,
    output logic [nse_pkg::PHASE_W-1:0]   phase,
    output logic [SIDE_W-1:0]             side_out
);

    localparam int W  = IN_W + nse_pkg::FRAC_SHIFT + nse_pkg::HEADROOM;
    localparam int NS = (STAGES < nse_pkg::MAX_STAGES) ? STAGES : nse_pkg::MAX_STAGES;

    logic signed [W-1:0]              x_reg     [0:NS];
    logic signed [W-1:0]              y_reg     [0:NS];
    logic [nse_pkg::PHASE_W-1:0]      ph_reg    [0:NS];
    logic                             valid_reg [0:NS];
    logic [SIDE_W-1:0]                side_reg  [0:NS];

    logic signed [W-1:0]              x_ext;
    logic signed [W-1:0]              y_ext;
    logic signed [W-1:0]              x0_next;
    logic signed [W-1:0]              y0_next;
    logic [nse_pkg::PHASE_W-1:0]      ph0_next;

    // entry: fold left half-plane onto the right, start from pi there
    always_comb
    begin
        x_ext = {{(W-IN_W){vec_x[IN_W-1]}}, vec_x} <<< nse_pkg::FRAC_SHIFT;
        y_ext = {{(W-IN_W){vec_y[IN_W-1]}}, vec_y} <<< nse_pkg::FRAC_SHIFT;
        if (vec_x[IN_W-1])
        begin
            x0_next  = -x_ext;
            y0_next  = -y_ext;
            ph0_next = nse_pkg::PHASE_PI;
        end
        else
        begin
            x0_next  = x_ext;
            y0_next  = y_ext;
            ph0_next = nse_pkg::PHASE_ZERO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0]    <= x0_next;
            y_reg[0]    <= y0_next;
            ph_reg[0]   <= ph0_next;
            side_reg[0] <= side_in;
        end
    end

    // vectoring micro-rotations, one per stage
    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic signed [W-1:0]         dx;
        logic signed [W-1:0]         dy;
        logic                        up;
        logic signed [W-1:0]         x_next;
        logic signed [W-1:0]         y_next;
        logic [nse_pkg::PHASE_W-1:0] ph_next;

        always_comb
        begin
            dx = y_reg[k] >>> k;
            dy = x_reg[k] >>> k;
            up = !y_reg[k][W-1] && (y_reg[k] != '0);
            if (up)
            begin
                x_next  = x_reg[k] + dx;
                y_next  = y_reg[k] - dy;
                ph_next = ph_reg[k] + nse_pkg::ATAN_PHASE[k];
            end
            else
            begin
                x_next  = x_reg[k] - dx;
                y_next  = y_reg[k] + dy;
                ph_next = ph_reg[k] - nse_pkg::ATAN_PHASE[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[k+1]    <= x_next;
                y_reg[k+1]    <= y_next;
                ph_reg[k+1]   <= ph_next;
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[NS];
    assign phase     = ph_reg[NS];
    assign side_out  = side_reg[NS];

endmodule

`default_nettype wire

// ===== hdl/normal_spherical_encoder.sv =====
// stages: a radicand register, one square-root stage per root bit, a cordic entry register,
//   one cordic stage per micro-rotation, a product register and an output register
// throughput: one normal per cycle while the output slot is free or being taken,
//   every stage registered and advancing together
// reset: rst_n clears all valid bits asynchronously; the pipeline comes up empty
`default_nettype none

module normal_spherical_encoder #(
    parameter int COMPONENT_BITS = 16,
    parameter int CORDIC_STAGES  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [COMPONENT_BITS-1:0]  normal_x,
    input  logic signed [COMPONENT_BITS-1:0]  normal_y,
    input  logic signed [COMPONENT_BITS-1:0]  normal_z,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [15:0]                       normal_code
);

    localparam int CB     = COMPONENT_BITS;
    localparam int RAD_W  = 2 * CB;
    localparam int SIDE_W = 3 * CB + 1;
    localparam int AZ_W   = $bits(nse_pkg::az_flags_t);
    localparam int PO_W   = $bits(nse_pkg::po_flags_t);
    localparam int PW     = nse_pkg::PHASE_W;
    localparam int QW     = nse_pkg::PROD_W;
    localparam logic [RAD_W-1:0] ONE_SQ = {2'b01, {(RAD_W-2){1'b0}}};

    logic adv;
    logic out_valid_reg;

    // whole pipeline moves when the output slot is free or being taken
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // stage 1: radicand one - z*z
    logic signed [RAD_W-1:0] z_sq;
    logic [RAD_W-1:0]        rad_reg;
    logic [SIDE_W-1:0]       side1_reg;
    logic                    valid1_reg;

    assign z_sq = normal_z * normal_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad_reg   <= ONE_SQ - z_sq;
            side1_reg <= {normal_x, normal_y, normal_z,
                          (normal_x == '0) && (normal_y == '0)};
        end
    end

    // square root for the sine of the polar angle
    logic              sq_valid;
    logic [CB-1:0]     sq_root;
    logic [SIDE_W-1:0] sq_side;

    nse_isqrt #(
        .RAD_W  (RAD_W),
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (valid1_reg),
        .radicand  (rad_reg),
        .side_in   (side1_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    // unpack the carried components and form the special-case flags
    logic signed [CB-1:0]  sq_x;
    logic signed [CB-1:0]  sq_y;
    logic signed [CB-1:0]  sq_z;
    logic signed [CB:0]    po_x;
    logic signed [CB:0]    po_y;
    nse_pkg::az_flags_t    az_flags_in;
    nse_pkg::po_flags_t    po_flags_in;

    always_comb
    begin
        sq_x = sq_side[3*CB:2*CB+1];
        sq_y = sq_side[2*CB:CB+1];
        sq_z = sq_side[CB:1];
        po_x = {sq_z[CB-1], sq_z};
        po_y = {1'b0, sq_root};
        az_flags_in.xy_zero = sq_side[0];
        az_flags_in.y_zero  = (sq_y == '0);
        az_flags_in.x_neg   = sq_x[CB-1];
        po_flags_in.pole    = sq_side[0] || (sq_root == '0);
        po_flags_in.z_neg   = sq_z[CB-1];
    end

    // azimuth and polar angles side by side
    logic                az_valid;
    logic [PW-1:0]       az_phase;
    logic [AZ_W-1:0]     az_side;
    logic                po_valid;
    logic [PW-1:0]       po_phase;
    logic [PO_W-1:0]     po_side;

    nse_cordic #(
        .IN_W   (CB),
        .STAGES (CORDIC_STAGES),
        .SIDE_W (AZ_W)
    ) u_cordic_az (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_valid),
        .vec_x     (sq_x),
        .vec_y     (sq_y),
        .side_in   (az_flags_in),
        .out_valid (az_valid),
        .phase     (az_phase),
        .side_out  (az_side)
    );

    nse_cordic #(
        .IN_W   (CB + 1),
        .STAGES (CORDIC_STAGES),
        .SIDE_W (PO_W)
    ) u_cordic_po (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_valid),
        .vec_x     (po_x),
        .vec_y     (po_y),
        .side_in   (po_flags_in),
        .out_valid (po_valid),
        .phase     (po_phase),
        .side_out  (po_side)
    );

    // scale both phases by 255
    logic signed [QW-1:0]  az_ext;
    logic [PW-1:0]         po_abs;
    logic [QW-1:0]         po_ext;
    logic signed [QW-1:0]  prod_az_reg;
    logic [QW-1:0]         prod_po_reg;
    nse_pkg::az_flags_t    az_flags_reg;
    nse_pkg::po_flags_t    po_flags_reg;
    logic                  prod_valid_reg;

    always_comb
    begin
        az_ext = {{(QW-PW){az_phase[PW-1]}}, az_phase};
        po_abs = po_phase[PW-1] ? (~po_phase + 1'b1) : po_phase;
        po_ext = {{(QW-PW){1'b0}}, po_abs};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            prod_valid_reg <= az_valid && po_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_az_reg  <= (az_ext <<< 8) - az_ext;
            prod_po_reg  <= (po_ext << 8) - po_ext;
            az_flags_reg <= az_side;
            po_flags_reg <= po_side;
        end
    end

    // final codes with the axis and pole cases
    logic [QW-1:0]                az_sum;
    logic [nse_pkg::CODE_W-1:0]   az_code;
    logic [nse_pkg::CODE_W-1:0]   po_code;
    logic [15:0]                  code_reg;

    always_comb
    begin
        az_sum = prod_az_reg + (prod_az_reg[QW-1] ? nse_pkg::TRUNC_BIAS : '0);
        if (az_flags_reg.xy_zero)
        begin
            az_code = nse_pkg::CODE_ZERO;
        end
        else if (az_flags_reg.y_zero)
        begin
            az_code = az_flags_reg.x_neg ? nse_pkg::CODE_HALF_TURN : nse_pkg::CODE_ZERO;
        end
        else
        begin
            az_code = az_sum[QW-1:PW];
        end

        if (po_flags_reg.pole)
        begin
            po_code = po_flags_reg.z_neg ? nse_pkg::CODE_MAX : nse_pkg::CODE_ZERO;
        end
        else
        begin
            po_code = prod_po_reg[PW+6:PW-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            code_reg <= {po_code, az_code};
        end
    end

    assign out_valid   = out_valid_reg;
    assign normal_code = code_reg;

endmodule

`default_nettype wire
